>>> rtl/core/micro_flags_and_branch_condition_top_defines.svh
// Assertion macros shared by the micro flag and branch condition checker.
`ifndef MICRO_FLAGS_AND_BRANCH_CONDITION_TOP_DEFINES_SVH
`define MICRO_FLAGS_AND_BRANCH_CONDITION_TOP_DEFINES_SVH

// Property checked only while out of reset
`define MFBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define MFBC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mfbc_pkg.sv
// Package: request types and select codes for the micro flag and branch condition block.
`timescale 1ns / 1ps

package mfbc_pkg;

    // Zero flag source selects
    localparam logic [1:0] ZSRC_HOLD  = 2'd0;
    localparam logic [1:0] ZSRC_ALU   = 2'd1;
    localparam logic [1:0] ZSRC_AND   = 2'd2;
    localparam logic [1:0] ZSRC_CLEAR = 2'd3;

    // Carry flag source selects
    localparam logic [1:0] CSRC_HOLD  = 2'd0;
    localparam logic [1:0] CSRC_CARRY = 2'd1;
    localparam logic [1:0] CSRC_LSB   = 2'd2;
    localparam logic [1:0] CSRC_MSB   = 2'd3;

    // ALU status bit positions
    localparam int ALU_ZERO  = 0;
    localparam int ALU_CARRY = 1;
    localparam int ALU_OVF   = 2;
    localparam int ALU_SIGN  = 3;
    localparam int ALU_LSB   = 4;
    localparam int ALU_MSB   = 5;

    // Flag bit positions (micro flags and low machine bits)
    localparam int FLG_Z = 0;
    localparam int FLG_C = 1;
    localparam int FLG_S = 2;
    localparam int FLG_O = 3;

    // Machine status bit positions
    localparam int MCH_INT_EN = 4;
    localparam int MCH_MODE   = 5;
    localparam int MCH_DIR    = 6;
    localparam int MCH_DISP   = 7;

    // Event line positions
    localparam int EV_DMA  = 0;
    localparam int EV_WAIT = 1;
    localparam int EV_EXT  = 2;
    localparam int EV_IRQ  = 3;

    // Flag group conditions (select bit 3 low)
    localparam logic [2:0] CF_Z      = 3'd0;
    localparam logic [2:0] CF_C      = 3'd1;
    localparam logic [2:0] CF_S      = 3'd2;
    localparam logic [2:0] CF_O      = 3'd3;
    localparam logic [2:0] CF_LT     = 3'd4;
    localparam logic [2:0] CF_LE     = 3'd5;
    localparam logic [2:0] CF_BE     = 3'd6;
    localparam logic [2:0] CF_DMA    = 3'd7;

    // Status group conditions (select bit 3 high)
    localparam logic [2:0] CS_MODE   = 3'd0;
    localparam logic [2:0] CS_WAIT   = 3'd1;
    localparam logic [2:0] CS_IRQ    = 3'd2;
    localparam logic [2:0] CS_EXT    = 3'd3;
    localparam logic [2:0] CS_DIR    = 3'd4;
    localparam logic [2:0] CS_DISP   = 3'd5;

    typedef struct packed {
        logic [1:0] zero_source;
        logic [1:0] carry_source;
        logic       sign_source;
        logic       overflow_source;
        logic       escape_load;
        logic [1:0] escape_value;
        logic [5:0] alu_status;
        logic [3:0] cond_select;
        logic       cond_invert;
        logic       use_micro_flags;
        logic [7:0] machine_bits;
        logic [3:0] event_lines;
    } t_in;

    typedef struct packed {
        logic       condition;
        logic [3:0] micro_flags;
        logic [1:0] escape_code;
    } t_out;

endpackage

>>> rtl/core/mfbc_eval.sv
// Flag update and branch condition select for one microcycle request.
`timescale 1ns / 1ps

module mfbc_eval (
    input  mfbc_pkg::t_in  i_req,
    input  logic [3:0]     i_flags,
    input  logic [1:0]     i_escape,
    output mfbc_pkg::t_out o_res
);

    logic       z, c, s, o;
    logic       fz, fc, fs, fo;
    logic       cond;
    logic [5:0] alu;
    logic [7:0] mach;
    logic [3:0] ev;

    assign alu  = i_req.alu_status;
    assign mach = i_req.machine_bits;
    assign ev   = i_req.event_lines;

    // Zero flag
    always_comb begin
        case (i_req.zero_source)
            mfbc_pkg::ZSRC_HOLD:  z = i_flags[mfbc_pkg::FLG_Z];
            mfbc_pkg::ZSRC_ALU:   z = alu[mfbc_pkg::ALU_ZERO];
            mfbc_pkg::ZSRC_AND:   z = i_flags[mfbc_pkg::FLG_Z] & alu[mfbc_pkg::ALU_ZERO];
            mfbc_pkg::ZSRC_CLEAR: z = 1'b0;
            default:              z = 1'b0;
        endcase
    end

    // Carry flag
    always_comb begin
        case (i_req.carry_source)
            mfbc_pkg::CSRC_HOLD:  c = i_flags[mfbc_pkg::FLG_C];
            mfbc_pkg::CSRC_CARRY: c = alu[mfbc_pkg::ALU_CARRY];
            mfbc_pkg::CSRC_LSB:   c = alu[mfbc_pkg::ALU_LSB];
            mfbc_pkg::CSRC_MSB:   c = alu[mfbc_pkg::ALU_MSB];
            default:              c = 1'b0;
        endcase
    end

    // Sign and overflow: hold or take from the ALU
    assign s = i_req.sign_source ? alu[mfbc_pkg::ALU_SIGN] : i_flags[mfbc_pkg::FLG_S];
    assign o = i_req.overflow_source ? alu[mfbc_pkg::ALU_OVF] : i_flags[mfbc_pkg::FLG_O];

    // Flag set tested by the flag group: new micro flags or architectural
    assign fz = i_req.use_micro_flags ? z : mach[mfbc_pkg::FLG_Z];
    assign fc = i_req.use_micro_flags ? c : mach[mfbc_pkg::FLG_C];
    assign fs = i_req.use_micro_flags ? s : mach[mfbc_pkg::FLG_S];
    assign fo = i_req.use_micro_flags ? o : mach[mfbc_pkg::FLG_O];

    // Condition select
    always_comb begin
        cond = 1'b0;
        if (!i_req.cond_select[3]) begin
            case (i_req.cond_select[2:0])
                mfbc_pkg::CF_Z:   cond = fz;
                mfbc_pkg::CF_C:   cond = fc;
                mfbc_pkg::CF_S:   cond = fs;
                mfbc_pkg::CF_O:   cond = fo;
                mfbc_pkg::CF_LT:  cond = fs ^ fo;
                mfbc_pkg::CF_LE:  cond = fz | (fs ^ fo);
                mfbc_pkg::CF_BE:  cond = fz | fc;
                mfbc_pkg::CF_DMA: cond = ev[mfbc_pkg::EV_DMA];
                default:          cond = 1'b0;
            endcase
        end else begin
            case (i_req.cond_select[2:0])
                mfbc_pkg::CS_MODE: cond = mach[mfbc_pkg::MCH_MODE];
                mfbc_pkg::CS_WAIT: cond = ev[mfbc_pkg::EV_WAIT];
                mfbc_pkg::CS_IRQ:  cond = ev[mfbc_pkg::EV_IRQ] & mach[mfbc_pkg::MCH_INT_EN];
                mfbc_pkg::CS_EXT:  cond = ev[mfbc_pkg::EV_EXT];
                mfbc_pkg::CS_DIR:  cond = mach[mfbc_pkg::MCH_DIR];
                mfbc_pkg::CS_DISP: cond = mach[mfbc_pkg::MCH_DISP];
                // unused status selects read as false
                default:           cond = 1'b0;
            endcase
        end
    end

    // Result
    assign o_res.condition   = cond ^ i_req.cond_invert;
    assign o_res.micro_flags = {o, s, c, z};
    assign o_res.escape_code = i_req.escape_load ? i_req.escape_value : i_escape;

endmodule

>>> rtl/core/micro_flags_and_branch_condition_top.sv
// Top level: micro flag register and branch condition selector with request pipeline.
`timescale 1ns / 1ps

// Takes one microcycle request per clock and returns one result per request, in
// order. A request is captured in an input register; from there it is evaluated
// against the micro flag and escape state, that state is written, and the result
// lands in an output register. Throughput is one request per cycle when the output
// side keeps up; the state write happens only when a request moves into the output
// register, and a stall on the output side holds both registers, with input ready
// dropping once the input register is full.

module micro_flags_and_branch_condition_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mfbc_pkg::t_in   i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mfbc_pkg::t_out  o_out_req
);

    logic           r_in_valid, n_in_valid;
    mfbc_pkg::t_in  r_in;
    logic           r_out_valid, n_out_valid;
    mfbc_pkg::t_out r_out;
    logic [3:0]     r_flags;
    logic [1:0]     r_escape;
    mfbc_pkg::t_out res;
    logic           advance;
    logic           in_take;

    // Handshake control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign n_in_valid  = in_take || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    // Evaluate the held request
    mfbc_eval u_eval (
        .i_req    (r_in),
        .i_flags  (r_flags),
        .i_escape (r_escape),
        .o_res    (res)
    );

    // Control and flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= 4'd0;
            r_escape    <= 2'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_flags  <= res.micro_flags;
                r_escape <= res.escape_code;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_req;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

>>> rtl/core/mfbc_checker.sv
// Port checker for the micro flag and branch condition block, with its bind.
`timescale 1ns / 1ps
`include "micro_flags_and_branch_condition_top_defines.svh"

module mfbc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input mfbc_pkg::t_out o_out_req
);

    // stalled result stays offered
    `MFBC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // stalled result keeps its payload
    `MFBC_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_req), "result changed while stalled")

    // an empty output side never blocks a request
    `MFBC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input blocked with empty output")

    // nothing is offered right after a reset cycle
    `MFBC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind micro_flags_and_branch_condition_top mfbc_checker u_mfbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
